[design/asmr_pkg.sv]
`default_nettype none

package asmr_pkg;

    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int INNER_CFG_W = 9;
    localparam int OUTER_IDX_W = 16;
    localparam int MAX_OUTER   = 2 ** OUTER_IDX_W;
    localparam int ACC_MAX_W   = 64;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MODE_MEAN     = 2'd0;
    localparam t_cfg_idx CFG_REDUCE_LENGTH = 2'd1;
    localparam t_cfg_idx CFG_INNER_LENGTH  = 2'd2;
    localparam t_cfg_idx CFG_OUTER_LENGTH  = 2'd3;

endpackage

`default_nettype wire

[design/asmr_in_if.sv]
`default_nettype none

interface asmr_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink (input valid, input element, output ready);
endinterface

`default_nettype wire

[design/asmr_out_if.sv]
`default_nettype none

interface asmr_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] result_value;
    logic                         last_in_block;
    logic                         last_of_tensor;

    modport source (output valid, output result_value, output last_in_block,
                    output last_of_tensor, input ready);
    modport sink (input valid, input result_value, input last_in_block,
                  input last_of_tensor, output ready);
endinterface

`default_nettype wire

[design/asmr_alu.sv]
`default_nettype none

module asmr_alu #(
    parameter int WIDTH = 49
) (
    input  wire logic [WIDTH-1:0] i_a,
    input  wire logic [WIDTH-1:0] i_b,
    input  wire logic             i_cin,
    output logic      [WIDTH:0]   o_sum
);
    // The carry out doubles as the no-borrow flag when i_b is inverted.
    assign o_sum = {1'b0, i_a} + {1'b0, i_b} + {{WIDTH{1'b0}}, i_cin};
endmodule

`default_nettype wire

[design/asmr_acc_mem.sv]
`default_nettype none

module asmr_acc_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

[design/axis_sum_mean_reducer.sv]
// Axis sum and mean reducer.
// Elements enter on i_in in row-major order (outer, reduced, inner); one
// transaction carries one element. One result per inner position leaves on
// o_out after the last reduced row, flagged at the end of each outer block
// and at the end of the tensor.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data
// while the block is idle; the user must keep to this, as the block itself
// lacks any guard for it. Any write restarts the tensor at its first element.
// Each element is taken in a transaction and then accumulated by the shared
// adder that updates its accumulator; the input accepts no new transaction
// until that update is done. An element of the last reduced row then passes
// through an output step that hands its result to the output register. In
// mean mode that element first runs the restoring divider through the same
// adder, one quotient bit per cycle. The result appears on o_out in the cycle
// after the sequencer finishes.
// A stalled receiver holds the result in the output register; the block
// accepts further elements until the next result is ready and then waits.
// Reset clears the sequencer, the indices and the output valid, and sets the
// sum mode with every length at one. The accumulator memory is not cleared:
// the first reduced row loads each entry before it is read.
`default_nettype none

module axis_sum_mean_reducer
    import asmr_pkg::*;
#(
    parameter int MAX_INNER  = 256,
    parameter int MAX_REDUCE = 65536,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire t_cfg_idx       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    asmr_in_if.sink             i_in,
    asmr_out_if.source          o_out
);
    localparam int ACC_SUM_W = DATA_WIDTH + $clog2(MAX_REDUCE);
    localparam int ACC_W     = (ACC_SUM_W > ACC_MAX_W) ? ACC_MAX_W : ACC_SUM_W;
    localparam int AW        = ACC_W + 1;
    localparam int RIDX_W    = $clog2(MAX_REDUCE);
    localparam int RED_W     = RIDX_W + 1;
    localparam int IW        = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int CNT_W     = $clog2(ACC_W + 1);
    localparam int RCW       = (RED_W > CFG_W) ? RED_W : CFG_W;
    localparam int ICW       = (IW + 1 > INNER_CFG_W) ? IW + 1 : INNER_CFG_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_ABS  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_NEG  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic                   r_mode;
    logic [RED_W-1:0]       r_nred;
    logic [IW-1:0]          r_inn_last;
    logic [OUTER_IDX_W-1:0] r_out_last;
    logic [IW-1:0]          r_inner;
    logic [RIDX_W-1:0]      r_red;
    logic [OUTER_IDX_W-1:0] r_outer;
    logic [DATA_WIDTH-1:0]  r_elem;
    logic [ACC_W-1:0]       r_q;
    logic [RIDX_W-1:0]      r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_neg;
    logic                   r_last_in;
    logic                   r_last_all;
    logic                   r_out_valid;
    logic [DATA_WIDTH-1:0]  r_out_value;
    logic                   r_out_last_in;
    logic                   r_out_last_all;

    logic [ACC_W-1:0]  rd_data;
    logic [AW-1:0]     alu_a;
    logic [AW-1:0]     alu_b;
    logic              alu_cin;
    logic [AW:0]       alu_sum;
    logic [ACC_W-1:0]  acc_new;
    logic [RED_W-1:0]  rem_shift;
    logic              div_ge;
    logic [RIDX_W-1:0] red_last_idx;
    logic              last_row;
    logic              last_in;
    logic              last_all;
    logic              out_free;
    logic              mem_we;

    logic [RCW-1:0]         red_v;
    logic [RED_W-1:0]       nred_cfg;
    logic [ICW-1:0]         inn_v;
    logic [IW-1:0]          inn_last_cfg;
    logic [CFG_W-1:0]       out_v;
    logic [OUTER_IDX_W-1:0] out_last_cfg;

    always_comb begin
        red_v = RCW'(i_cfg_data);
        if (red_v == '0) begin
            nred_cfg = RED_W'(1);
        end else if (red_v > RCW'(MAX_REDUCE)) begin
            nred_cfg = RED_W'(MAX_REDUCE);
        end else begin
            nred_cfg = red_v[RED_W-1:0];
        end

        inn_v = ICW'(i_cfg_data[INNER_CFG_W-1:0]);
        if (inn_v == '0) begin
            inn_last_cfg = '0;
        end else if (inn_v > ICW'(MAX_INNER)) begin
            inn_last_cfg = IW'(MAX_INNER - 1);
        end else begin
            inn_last_cfg = IW'(inn_v - ICW'(1));
        end

        out_v = i_cfg_data;
        if (out_v == '0) begin
            out_last_cfg = '0;
        end else if (out_v > CFG_W'(MAX_OUTER)) begin
            out_last_cfg = OUTER_IDX_W'(MAX_OUTER - 1);
        end else begin
            out_last_cfg = OUTER_IDX_W'(out_v - CFG_W'(1));
        end
    end

    assign red_last_idx = RIDX_W'(r_nred - RED_W'(1));
    assign last_row     = (r_red == red_last_idx);
    assign last_in      = (r_inner == r_inn_last);
    assign last_all     = last_in && (r_outer == r_out_last);
    assign rem_shift    = {r_rem, r_q[ACC_W-1]};
    assign acc_new      = alu_sum[ACC_W-1:0];
    assign div_ge       = alu_sum[AW];
    assign out_free     = !r_out_valid || o_out.ready;
    assign mem_we       = (r_state == S_ADD);

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        case (r_state)
            S_ADD: begin
                alu_a = (r_red == '0) ? '0 : {rd_data[ACC_W-1], rd_data};
                alu_b = {{(AW - DATA_WIDTH){r_elem[DATA_WIDTH-1]}}, r_elem};
            end
            S_ABS, S_NEG: begin
                alu_b   = r_neg ? ~{1'b0, r_q} : {1'b0, r_q};
                alu_cin = r_neg;
            end
            S_DIV: begin
                alu_a   = AW'(rem_shift);
                alu_b   = ~AW'(r_nred);
                alu_cin = 1'b1;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (!last_row) begin
                    n_state = S_IDLE;
                end else if (r_mode) begin
                    n_state = S_ABS;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_ABS: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_NEG;
                end
            end
            S_NEG: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    asmr_alu #(
        .WIDTH (AW)
    ) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_cin (alu_cin),
        .o_sum (alu_sum)
    );

    asmr_acc_mem #(
        .DEPTH  (MAX_INNER),
        .ADDR_W (IW),
        .DATA_W (ACC_W)
    ) u_acc_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_inner),
        .i_wdata (acc_new),
        .i_raddr (r_inner),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= 1'b0;
            r_nred     <= RED_W'(1);
            r_inn_last <= '0;
            r_out_last <= '0;
            r_inner    <= '0;
            r_red      <= '0;
            r_outer    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE_MEAN:     r_mode     <= i_cfg_data[0];
                    CFG_REDUCE_LENGTH: r_nred     <= nred_cfg;
                    CFG_INNER_LENGTH:  r_inn_last <= inn_last_cfg;
                    CFG_OUTER_LENGTH:  r_out_last <= out_last_cfg;
                    default:           r_mode     <= r_mode;
                endcase
                r_inner <= '0;
                r_red   <= '0;
                r_outer <= '0;
            end else if (r_state == S_ADD) begin
                if (last_in) begin
                    r_inner <= '0;
                    if (last_row) begin
                        r_red   <= '0;
                        r_outer <= (r_outer == r_out_last) ? '0 : r_outer + 1'b1;
                    end else begin
                        r_red <= r_red + 1'b1;
                    end
                end else begin
                    r_inner <= r_inner + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_elem <= i_in.element;
            end
            S_ADD: begin
                r_q        <= acc_new;
                r_neg      <= acc_new[ACC_W-1];
                r_last_in  <= last_in;
                r_last_all <= last_all;
            end
            S_ABS: begin
                r_q   <= acc_new;
                r_rem <= '0;
                r_cnt <= CNT_W'(ACC_W);
            end
            S_DIV: begin
                r_q   <= {r_q[ACC_W-2:0], div_ge};
                r_rem <= div_ge ? alu_sum[RIDX_W-1:0] : rem_shift[RIDX_W-1:0];
                r_cnt <= r_cnt - 1'b1;
            end
            S_NEG: begin
                r_q <= acc_new;
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_value    <= r_q[DATA_WIDTH-1:0];
            r_out_last_in  <= r_last_in;
            r_out_last_all <= r_last_all;
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.result_value   = r_out_value;
    assign o_out.last_in_block  = r_out_last_in;
    assign o_out.last_of_tensor = r_out_last_all;

    a_accept_starts_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_cfg_we) |=> (r_state == S_ADD))
        else $error("accepted transaction did not reach the accumulate step");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (RED_W'(r_rem) < r_nred))
        else $error("divider remainder not below the reduced length");

    a_div_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != '0))
        else $error("divider running with an exhausted bit count");

    a_tensor_end_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last_all) |-> r_out_last_in)
        else $error("tensor end flagged without block end");
endmodule

`default_nettype wire

[verif/axis_sum_mean_reducer_tb.sv]
module axis_sum_mean_reducer_tb;
    import asmr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W         = 32;
    localparam int MAX_INNER_N    = 256;
    localparam int MAX_REDUCE_N   = 65536;
    localparam int SETTLE_CYCLES  = 80;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 900;
    localparam int PHASE_CAP      = 200;
    localparam int LONG_REDUCE    = 300;
    localparam int OUTER_ITEMS    = 48;

    typedef logic signed [DATA_W-1:0] elem_t;

    typedef struct packed {
        elem_t value;
        logic  last_in_block;
        logic  last_of_tensor;
    } axis_result_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_style_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    t_cfg_idx               cfg_index = CFG_MODE_MEAN;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   in_valid = 1'b0;
    elem_t                  in_element = '0;
    logic                   out_ready = 1'b0;

    asmr_in_if  #(.DATA_WIDTH(DATA_W)) in_if ();
    asmr_out_if #(.DATA_WIDTH(DATA_W)) out_if ();

    assign in_if.valid   = in_valid;
    assign in_if.element = in_element;
    assign out_if.ready  = out_ready;

    axis_sum_mean_reducer #(
        .MAX_INNER  (MAX_INNER_N),
        .MAX_REDUCE (MAX_REDUCE_N),
        .DATA_WIDTH (DATA_W)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #10 clk = ~clk;

    elem_t          pending_elements[$];
    axis_result_t   expected_results[$];
    int             failures = 0;
    int             sender_gap_max = 0;
    int             holds_asked = 0;
    int             random_items = 0;

    // Mirror of the block's registers and indices.
    longint                 acc_mem [MAX_INNER_N];
    int unsigned            pos_inner, pos_reduce, pos_outer;
    logic                   mean_mode;
    logic [CFG_W-1:0]       reduce_reg, outer_reg;
    logic [INNER_CFG_W-1:0] inner_reg;

    function automatic int unsigned eff_len(input int unsigned raw, input int unsigned limit);
        if (raw == 0) return 1;
        return (raw > limit) ? limit : raw;
    endfunction

    function automatic void reset_mirror();
        mean_mode  = 1'b0;
        reduce_reg = CFG_W'(1);
        inner_reg  = INNER_CFG_W'(1);
        outer_reg  = CFG_W'(1);
        pos_inner  = 0;
        pos_reduce = 0;
        pos_outer  = 0;
    endfunction

    function automatic void reduce_element(input elem_t x);
        int unsigned  nred, ninn, nout;
        longint       sum, quot;
        axis_result_t r;
        nred = eff_len(reduce_reg, MAX_REDUCE_N);
        ninn = eff_len(inner_reg, MAX_INNER_N);
        nout = eff_len(outer_reg, MAX_OUTER);
        sum = (pos_reduce == 0) ? longint'(x) : acc_mem[pos_inner] + longint'(x);
        acc_mem[pos_inner] = sum;
        if (pos_reduce + 1 >= nred) begin
            quot = sum / longint'(nred);
            r.value          = mean_mode ? quot[DATA_W-1:0] : sum[DATA_W-1:0];
            r.last_in_block  = (pos_inner + 1 >= ninn);
            r.last_of_tensor = r.last_in_block && (pos_outer + 1 >= nout);
            expected_results.push_back(r);
        end
        pos_inner++;
        if (pos_inner >= ninn) begin
            pos_inner = 0;
            pos_reduce++;
            if (pos_reduce >= nred) begin
                pos_reduce = 0;
                pos_outer++;
                if (pos_outer >= nout) pos_outer = 0;
            end
        end
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10) $display("%s", msg);
    endfunction

    function automatic void check_result(input axis_result_t got);
        axis_result_t want;
        if (expected_results.size() == 0) begin
            note_failure($sformatf("unexpected result: value %0d last_in_block %0b last_of_tensor %0b",
                                   got.value, got.last_in_block, got.last_of_tensor));
            return;
        end
        want = expected_results.pop_front();
        if (got.value !== want.value || got.last_in_block !== want.last_in_block ||
                got.last_of_tensor !== want.last_of_tensor) begin
            note_failure($sformatf({"result mismatch: expected %0d/%0b/%0b, ",
                                    "got %0d/%0b/%0b (value/last_in_block/last_of_tensor)"},
                                   want.value, want.last_in_block, want.last_of_tensor,
                                   got.value, got.last_in_block, got.last_of_tensor));
        end
    endfunction

    function automatic elem_t rand_element();
        case ($urandom_range(0, 9))
            0: return elem_t'(32'h7FFF_FFFF);
            1: return elem_t'(32'h8000_0000);
            2: return elem_t'($urandom_range(0, 2)) - elem_t'(1);
            3, 4: return elem_t'($urandom_range(0, 2000)) - elem_t'(1000);
            default: return elem_t'($urandom);
        endcase
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MODE_MEAN:     mean_mode = data[0];
            CFG_REDUCE_LENGTH: reduce_reg = data;
            CFG_INNER_LENGTH:  inner_reg = data[INNER_CFG_W-1:0];
            CFG_OUTER_LENGTH:  outer_reg = data;
            default: ;
        endcase
        pos_inner  = 0;
        pos_reduce = 0;
        pos_outer  = 0;
    endtask

    task automatic configure(input logic mode, input logic [CFG_W-1:0] red,
                             input logic [INNER_CFG_W-1:0] inn, input logic [CFG_W-1:0] outr);
        write_reg(CFG_MODE_MEAN, CFG_W'(mode));
        write_reg(CFG_REDUCE_LENGTH, red);
        write_reg(CFG_INNER_LENGTH, CFG_W'(inn));
        write_reg(CFG_OUTER_LENGTH, outr);
    endtask

    task automatic drain();
        while (pending_elements.size() != 0 || expected_results.size() != 0 || in_valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_random(input int unsigned count);
        repeat (count) pending_elements.push_back(rand_element());
    endtask

    task automatic random_phase();
        logic                   mode;
        logic [CFG_W-1:0]       red, outr;
        logic [INNER_CFG_W-1:0] inn;
        longint unsigned        tensor;
        int unsigned            count;
        mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: red = '0;
            1: red = '1;
            2: red = CFG_W'($urandom_range(9, 40));
            default: red = CFG_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 11))
            0: inn = '0;
            1: inn = '1;
            2: inn = INNER_CFG_W'(MAX_INNER_N);
            3: inn = INNER_CFG_W'($urandom_range(17, 255));
            default: inn = INNER_CFG_W'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 9))
            0: outr = '0;
            1: outr = '1;
            default: outr = CFG_W'($urandom_range(1, 4));
        endcase
        configure(mode, red, inn, outr);
        tensor = longint'(eff_len(red, MAX_REDUCE_N)) * eff_len(inn, MAX_INNER_N)
                 * eff_len(outr, MAX_OUTER);
        // Mostly whole tensors; the rest stops part-way and is restarted by the next write.
        if (tensor <= PHASE_CAP && $urandom_range(0, 4) != 0)
            count = int'(tensor) * $urandom_range(1, PHASE_CAP / int'(tensor));
        else
            count = $urandom_range(1, (tensor < PHASE_CAP) ? int'(tensor) : PHASE_CAP);
        sender_gap_max = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
        push_random(count);
        random_items += count;
        drain();
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!in_valid || in_if.ready) begin
            if (in_valid) void'(pending_elements.pop_front());
            if (gap_left != 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_elements.size() != 0) begin
                in_valid   <= 1'b1;
                in_element <= pending_elements[0];
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = (sender_gap_max == 0 || $urandom_range(0, 3) == 0) ?
                               0 : $urandom_range(1, sender_gap_max);
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: changes its stall pattern now and then, and holds off for a long
    // stretch whenever one is requested.
    rx_style_t rx_style = RX_OPEN;
    int rx_left = 0;
    int rx_tick = 0;
    int hold_left = 0;
    int holds_done = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_style = rx_style_t'($urandom_range(0, 3));
                rx_left  = $urandom_range(8, 80);
            end else begin
                rx_left--;
            end
            rx_tick++;
            case (rx_style)
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= (rx_tick % 3 != 0);
            endcase
        end
    end

    // Monitor: each result transaction is checked, each element transaction predicted.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_if.valid && out_ready)
                check_result('{out_if.result_value, out_if.last_in_block, out_if.last_of_tensor});
            if (in_valid && in_if.ready) reduce_element(in_element);
        end
    end

    int stall_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_if.ready) || (out_if.valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("axis_sum_mean_reducer verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        reset_mirror();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: sum over a single element.
        sender_gap_max = 3;
        pending_elements.push_back(elem_t'(32'h7FFF_FFFF));
        pending_elements.push_back(elem_t'(32'h8000_0000));
        pending_elements.push_back(elem_t'(0));
        pending_elements.push_back(elem_t'(-1));
        drain();

        // Sum wraps to the element width.
        configure(1'b0, CFG_W'(2), INNER_CFG_W'(2), CFG_W'(1));
        pending_elements.push_back(elem_t'(32'h7FFF_FFFF));
        pending_elements.push_back(elem_t'(32'h7FFF_FFFF));
        pending_elements.push_back(elem_t'(1));
        pending_elements.push_back(elem_t'(32'h8000_0000));
        drain();

        // Mean truncates toward zero, and the tensor end wraps into a new tensor.
        configure(1'b1, CFG_W'(3), INNER_CFG_W'(1), CFG_W'(2));
        pending_elements.push_back(elem_t'(-7));
        pending_elements.push_back(elem_t'(0));
        pending_elements.push_back(elem_t'(0));
        pending_elements.push_back(elem_t'(7));
        pending_elements.push_back(elem_t'(0));
        pending_elements.push_back(elem_t'(0));
        repeat (3) pending_elements.push_back(elem_t'(32'h8000_0000));
        drain();

        // Zero lengths behave as one.
        configure(1'b1, '0, '0, '0);
        pending_elements.push_back(elem_t'(32'h7FFF_FFFF));
        pending_elements.push_back(elem_t'(32'h8000_0000));
        drain();

        // A register write part-way through discards the partial sum.
        configure(1'b0, CFG_W'(2), INNER_CFG_W'(1), CFG_W'(1));
        pending_elements.push_back(elem_t'(100));
        drain();
        write_reg(CFG_MODE_MEAN, CFG_W'(0));
        pending_elements.push_back(elem_t'(3));
        pending_elements.push_back(elem_t'(4));
        drain();

        // The receiver holds off while the sender keeps offering, so the block fills up.
        configure(1'b0, CFG_W'(1), INNER_CFG_W'(4), CFG_W'(8));
        sender_gap_max = 0;
        push_random(64);
        holds_asked++;
        drain();

        // Long reduced axis in mean mode.
        configure(1'b1, CFG_W'(LONG_REDUCE), INNER_CFG_W'(1), CFG_W'(1));
        sender_gap_max = 1;
        push_random(LONG_REDUCE);
        drain();

        // Oversized inner length is limited to the accumulator count.
        configure(1'b0, CFG_W'(2), '1, CFG_W'(1));
        sender_gap_max = 2;
        push_random(2 * MAX_INNER_N);
        drain();

        // Oversized outer length: single-element results that never end the tensor.
        configure(1'b0, CFG_W'(1), INNER_CFG_W'(1), '1);
        sender_gap_max = 0;
        push_random(OUTER_ITEMS);
        drain();

        while (random_items < RANDOM_ITEMS) random_phase();

        if (failures == 0) begin
            $display("axis_sum_mean_reducer verification clean");
        end else begin
            $display("axis_sum_mean_reducer verification failed");
        end
        $finish;
    end

endmodule

[axis_sum_mean_reducer.f]
design/asmr_pkg.sv
design/asmr_in_if.sv
design/asmr_out_if.sv
design/asmr_alu.sv
design/asmr_acc_mem.sv
design/axis_sum_mean_reducer.sv
verif/axis_sum_mean_reducer_tb.sv
